// ----- design/b64s_pkg.sv -----
// Shared types, constants and character mapping functions for the base64url stream codec.
package b64s_pkg;

  // Encoder group phases: bytes already taken in the current 3-byte group.
  localparam logic [1:0] EncPh0 = 2'd0;
  localparam logic [1:0] EncPh1 = 2'd1;
  localparam logic [1:0] EncPh2 = 2'd2;

  localparam logic [7:0] CharPad = 8'h3D;  // '='

  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } b64s_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } b64s_res_t;

  // Results produced by one item: cnt of them, r0 first.
  typedef struct packed {
    logic [1:0] cnt;
    b64s_res_t  r0;
    b64s_res_t  r1;
  } b64s_push_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } b64s_sym_t;

  function automatic logic [7:0] enc_char(input logic [5:0] six);
    logic [7:0] c;
    if (six < 6'd26) begin
      c = 8'h41 + {2'b00, six};
    end else if (six < 6'd52) begin
      c = 8'h61 + {2'b00, six} - 8'd26;
    end else if (six < 6'd62) begin
      c = 8'h30 + {2'b00, six} - 8'd52;
    end else if (six == 6'd62) begin
      c = 8'h2D;
    end else begin
      c = 8'h5F;
    end
    return c;
  endfunction

  // Accepts both the URL-safe and the standard alphabet.
  function automatic b64s_sym_t dec_sym(input logic [7:0] c);
    b64s_sym_t s;
    s.ok  = 1'b1;
    s.val = 6'd0;
    if (c inside {[8'h41:8'h5A]}) begin
      s.val = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      s.val = 6'(c - 8'h61 + 8'd26);
    end else if (c inside {[8'h30:8'h39]}) begin
      s.val = 6'(c - 8'h30 + 8'd52);
    end else if (c inside {8'h2D, 8'h2B}) begin
      s.val = 6'd62;
    end else if (c inside {8'h5F, 8'h2F}) begin
      s.val = 6'd63;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

// ----- design/b64s_core.sv -----
// Codec state registers and the per-item encode and decode logic.
module b64s_core import b64s_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       dir_i,
  input  b64s_item_t item_i,
  input  logic       adv_i,
  output b64s_push_t push_o
);

  logic [1:0] enc_phase_q, enc_phase_d;
  logic [3:0] enc_left_q, enc_left_d;
  logic [2:0] dec_pend_q, dec_pend_d;
  logic [5:0] dec_left_q, dec_left_d;
  logic       dec_stop_q, dec_stop_d;

  logic [1:0]  phase;
  logic [7:0]  b;
  logic [7:0]  c0, c1;
  logic [1:0]  enc_cnt;
  b64s_sym_t   sym;
  logic [11:0] comb;
  logic [2:0]  keep;
  logic [11:0] shifted;
  logic [5:0]  mask;
  logic        have;
  logic [7:0]  dbyte;

  assign b     = item_i.data;
  assign phase = (enc_phase_q == 2'd3) ? EncPh0 : enc_phase_q;

  always_comb begin
    enc_phase_d = enc_phase_q;
    enc_left_d  = enc_left_q;
    c0          = 8'd0;
    c1          = 8'd0;
    enc_cnt     = 2'd1;
    case (phase)
      EncPh0: begin
        c0          = enc_char(b[7:2]);
        c1          = enc_char({b[1:0], 4'b0000});
        enc_left_d  = {2'b00, b[1:0]};
        enc_phase_d = EncPh1;
        enc_cnt     = item_i.last ? 2'd2 : 2'd1;
      end
      EncPh1: begin
        c0          = enc_char({enc_left_q[1:0], b[7:4]});
        c1          = enc_char({b[3:0], 2'b00});
        enc_left_d  = b[3:0];
        enc_phase_d = EncPh2;
        enc_cnt     = item_i.last ? 2'd2 : 2'd1;
      end
      default: begin
        c0          = enc_char({enc_left_q, b[7:6]});
        c1          = enc_char(b[5:0]);
        enc_left_d  = 4'd0;
        enc_phase_d = EncPh0;
        enc_cnt     = 2'd2;
      end
    endcase
    if (item_i.last) begin
      enc_left_d  = 4'd0;
      enc_phase_d = EncPh0;
    end
  end

  assign sym     = dec_sym(b);
  assign comb    = {dec_left_q, sym.val};
  assign keep    = dec_pend_q - 3'd2;
  assign shifted = comb >> keep;
  assign mask    = (6'd1 << keep) - 6'd1;
  assign dbyte   = shifted[7:0];

  always_comb begin
    dec_pend_d = dec_pend_q;
    dec_left_d = dec_left_q;
    dec_stop_d = dec_stop_q;
    have       = 1'b0;
    if (!dec_stop_q) begin
      if (b == CharPad) begin
        dec_stop_d = 1'b1;
      end else if (sym.ok) begin
        if (dec_pend_q >= 3'd2) begin
          have       = 1'b1;
          dec_left_d = comb[5:0] & mask;
          dec_pend_d = keep;
        end else begin
          dec_left_d = sym.val;
          dec_pend_d = 3'd6;
        end
      end
    end
    if (item_i.last) begin
      dec_pend_d = 3'd0;
      dec_left_d = 6'd0;
      dec_stop_d = 1'b0;
    end
  end

  always_comb begin
    push_o = '0;
    if (dir_i) begin
      push_o.cnt      = (have || item_i.last) ? 2'd1 : 2'd0;
      push_o.r0.data  = have ? dbyte : 8'd0;
      push_o.r0.valid = have;
      push_o.r0.last  = item_i.last;
    end else begin
      push_o.cnt      = enc_cnt;
      push_o.r0.data  = c0;
      push_o.r0.valid = 1'b1;
      push_o.r0.last  = item_i.last && (enc_cnt == 2'd1);
      push_o.r1.data  = c1;
      push_o.r1.valid = 1'b1;
      push_o.r1.last  = item_i.last;
    end
  end

  // Each direction keeps its own state; only the active one moves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_phase_q <= EncPh0;
      enc_left_q  <= 4'd0;
      dec_pend_q  <= 3'd0;
      dec_left_q  <= 6'd0;
      dec_stop_q  <= 1'b0;
    end else if (adv_i) begin
      if (dir_i) begin
        dec_pend_q <= dec_pend_d;
        dec_left_q <= dec_left_d;
        dec_stop_q <= dec_stop_d;
      end else begin
        enc_phase_q <= enc_phase_d;
        enc_left_q  <= enc_left_d;
      end
    end
  end

endmodule

// ----- design/b64s_fifo.sv -----
// Result queue that takes up to two results per cycle and gives one per transfer.
module b64s_fifo import b64s_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_en_i,
  input  b64s_push_t push_i,
  output logic       room_o,
  output logic       valid_o,
  input  logic       stall_i,
  output b64s_res_t  res_o
);

  b64s_res_t mem_q [FifoDepth];

  logic [FifoPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic [1:0]          n_push;
  logic                pop;

  assign n_push  = push_en_i ? push_i.cnt : 2'd0;
  assign pop     = valid_o && !stall_i;
  assign valid_o = (cnt_q != '0);
  assign res_o   = mem_q[rd_q];
  // Two free entries are needed, whatever happens on the output side.
  assign room_o  = (cnt_q <= FifoCntW'(FifoDepth - 2));

  assign wr_d  = wr_q + FifoPtrW'(n_push);
  assign rd_d  = rd_q + FifoPtrW'(pop);
  assign cnt_d = cnt_q + FifoCntW'(n_push) - FifoCntW'(pop);

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_q + FifoPtrW'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- design/base64url_stream_codec_top.sv -----
// An accepted item waits in the input register until the result queue has room for two
// results; it then moves its results into that queue, which offers them from its head.
// Throughput: one item per cycle when each item gives at most one result and the result
// side does not stall; an item that gives two characters can hold the input, as the
// output queue gives one result per transfer. Reset clears the direction register (encode),
// the codec state and the input and result queues at once; no clearing pass follows.
module base64url_stream_codec_top import b64s_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_data_i,
  input  logic       in_last_i,
  output logic       res_valid_o,
  input  logic       res_stall_i,
  output logic [7:0] out_data_o,
  output logic       out_valid_o,
  output logic       out_last_o
);

  logic       dir_q;
  logic       vld_q;
  b64s_item_t item_q;
  logic       room;
  logic       adv;
  logic       take;
  b64s_push_t push;
  b64s_res_t  res;

  assign cfg_ready_o = 1'b1;

  assign adv        = vld_q && room;
  assign in_stall_o = vld_q && !room;
  assign take       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
      vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        dir_q <= cfg_data_i;
      end
      if (take) begin
        vld_q <= 1'b1;
      end else if (adv) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.data <= in_data_i;
      item_q.last <= in_last_i;
    end
  end

  b64s_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .dir_i  (dir_q),
    .item_i (item_q),
    .adv_i  (adv),
    .push_o (push)
  );

  b64s_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_en_i (adv),
    .push_i    (push),
    .room_o    (room),
    .valid_o   (res_valid_o),
    .stall_i   (res_stall_i),
    .res_o     (res)
  );

  assign out_data_o  = res.data;
  assign out_valid_o = res.valid;
  assign out_last_o  = res.last;

endmodule

// ----- design/b64s_checker.sv -----
// Port-level checker for the codec top level and its bind statement.
module b64s_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_o,
  input logic       res_stall_i,
  input logic [7:0] out_data_o,
  input logic       out_valid_o,
  input logic       out_last_o
);

  // A bare end marker only ever closes a string.
  a_bare_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !out_valid_o |-> out_last_o)
    else $error("bare end marker without last");

  a_bare_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !out_valid_o |-> out_data_o == 8'd0)
    else $error("bare end marker carries data");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> res_valid_o)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> $stable({out_data_o, out_valid_o, out_last_o}))
    else $error("stalled result changed");

endmodule

bind base64url_stream_codec_top b64s_checker u_b64s_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_o (res_valid_o),
  .res_stall_i (res_stall_i),
  .out_data_o  (out_data_o),
  .out_valid_o (out_valid_o),
  .out_last_o  (out_last_o)
);

// ----- verif/tb_top.sv -----
// Self-checking testbench for the base64url stream codec in both directions.
`timescale 1ns / 1ps

module tb_top import b64s_pkg::*; ();

  localparam logic DirEncode = 1'b0;
  localparam logic DirDecode = 1'b1;
  localparam int   IdleLimit = 2000;
  localparam int   CfgSettle = 8;
  localparam logic [6:0] SymNone = 7'd64;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_data_i = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_data_i = 8'h00;
  logic       in_last_i = 1'b0;
  logic       res_valid_o;
  logic       res_stall_i = 1'b0;
  logic [7:0] out_data_o;
  logic       out_valid_o;
  logic       out_last_o;

  base64url_stream_codec_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .in_last_i  (in_last_i),
    .res_valid_o(res_valid_o),
    .res_stall_i(res_stall_i),
    .out_data_o (out_data_o),
    .out_valid_o(out_valid_o),
    .out_last_o (out_last_o)
  );

  // Predictor state, one copy per direction plus the mode register.
  logic       mode_decode = DirEncode;
  logic [1:0] grp_phase = EncPh0;
  logic [3:0] grp_bits = 4'h0;
  logic [2:0] acc_count = 3'd0;
  logic [5:0] acc_bits = 6'h00;
  logic       pad_seen = 1'b0;

  b64s_res_t  awaited_outputs[$];
  string      url_alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

  bit         full_speed = 1'b0;
  int         errors = 0;
  int         n_bytes_in = 0;
  int         n_chars_in = 0;
  int         n_results = 0;
  int         n_cfg_writes = 0;
  int         idle_cycles = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [7:0] b64_char(input logic [5:0] six);
    return url_alpha[six];
  endfunction

  // Six-bit value of a character from either alphabet, SymNone if it is not one.
  function automatic logic [6:0] sym_value(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return 7'(c - "A");
    if (c >= "a" && c <= "z") return 7'(c - "a" + 8'd26);
    if (c >= "0" && c <= "9") return 7'(c - "0" + 8'd52);
    if (c == "-" || c == "+") return 7'd62;
    if (c == "_" || c == "/") return 7'd63;
    return SymNone;
  endfunction

  function automatic void expect_result(input logic [7:0] d, input logic v, input logic l);
    b64s_res_t r;
    r.data  = d;
    r.valid = v;
    r.last  = l;
    awaited_outputs = {awaited_outputs, r};
  endfunction

  function automatic void predict_codec_output(input logic [7:0] d, input logic l);
    logic [6:0]  sym;
    logic [11:0] comb;
    logic [7:0]  dec_out;
    logic        have;
    int          keep;
    have    = 1'b0;
    dec_out = 8'h00;
    if (mode_decode == DirEncode) begin
      case (grp_phase)
        EncPh1: begin
          expect_result(b64_char({grp_bits[1:0], d[7:4]}), 1'b1, 1'b0);
          grp_bits  = d[3:0];
          grp_phase = EncPh2;
          if (l) expect_result(b64_char({d[3:0], 2'b00}), 1'b1, 1'b1);
        end
        EncPh2: begin
          expect_result(b64_char({grp_bits, d[7:6]}), 1'b1, 1'b0);
          expect_result(b64_char(d[5:0]), 1'b1, l);
          grp_bits  = 4'h0;
          grp_phase = EncPh0;
        end
        default: begin
          expect_result(b64_char(d[7:2]), 1'b1, 1'b0);
          grp_bits  = {2'b00, d[1:0]};
          grp_phase = EncPh1;
          if (l) expect_result(b64_char({d[1:0], 4'h0}), 1'b1, 1'b1);
        end
      endcase
      if (l) begin
        grp_phase = EncPh0;
        grp_bits  = 4'h0;
      end
    end else begin
      if (!pad_seen) begin
        if (d == CharPad) begin
          pad_seen = 1'b1;
        end else begin
          sym = sym_value(d);
          if (sym != SymNone) begin
            if (acc_count >= 3'd2) begin
              comb      = {acc_bits, sym[5:0]};
              keep      = int'(acc_count) - 2;
              dec_out   = 8'(comb >> keep);
              have      = 1'b1;
              acc_bits  = 6'(comb & ((12'd1 << keep) - 12'd1));
              acc_count = 3'(keep);
            end else begin
              acc_bits  = sym[5:0];
              acc_count = 3'd6;
            end
          end
        end
      end
      if (l) begin
        acc_count = 3'd0;
        acc_bits  = 6'h00;
        pad_seen  = 1'b0;
        expect_result(dec_out, have, 1'b1);
      end else if (have) begin
        expect_result(dec_out, 1'b1, 1'b0);
      end
    end
  endfunction

  // True when the item does more than get skipped by the block.
  function automatic bit item_matters(input logic [7:0] c, input logic l);
    if (mode_decode == DirEncode || l) return 1'b1;
    if (pad_seen) return 1'b0;
    return (c == CharPad) || (sym_value(c) != SymNone);
  endfunction

  // Mostly alphabet characters, some noise bytes and some padding.
  function automatic logic [7:0] pick_char();
    int unsigned roll;
    logic [5:0]  v;
    roll = $urandom_range(0, 99);
    if (roll < 6) return 8'($urandom_range(0, 255));
    if (roll < 10) return CharPad;
    v = 6'($urandom_range(0, 63));
    if (v >= 6'd62 && $urandom_range(0, 1) == 1) return (v == 6'd62) ? "+" : "/";
    return b64_char(v);
  endfunction

  // Valid stays high from one item to the next when no gap is drawn.
  task automatic send_item(input logic [7:0] d, input logic l);
    int unsigned gap;
    gap = full_speed ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    in_last_i  <= l;
    do @(posedge clk_i); while (in_stall_o);
    predict_codec_output(d, l);
    if (mode_decode == DirDecode) n_chars_in++;
    else n_bytes_in++;
  endtask

  task automatic idle_input();
    in_valid_i <= 1'b0;
  endtask

  // Only called with the input side idle; items that give no result need the settle time.
  task automatic set_direction(input logic dir);
    while (awaited_outputs.size() != 0) @(posedge clk_i);
    repeat (CfgSettle) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= dir;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mode_decode = dir;
    n_cfg_writes++;
  endtask

  task automatic test_encode_groups();
    logic [8:0] seq [7] = '{
      {1'b1, 8'h00}, {1'b1, 8'hFF}, {1'b0, 8'hFB}, {1'b0, 8'hEF},
      {1'b1, 8'hBF}, {1'b0, 8'h80}, {1'b1, 8'h01}
    };
    set_direction(DirEncode);
    foreach (seq[i]) send_item(seq[i][7:0], seq[i][8]);
    idle_input();
  endtask

  task automatic test_decode_cases();
    logic [8:0] seq [19] = '{
      {1'b0, "Q"}, {1'b0, "U"}, {1'b0, "J"}, {1'b1, "D"},
      {1'b0, "-"}, {1'b0, "_"}, {1'b0, "+"}, {1'b1, "/"},
      {1'b0, "A"}, {1'b0, 8'h21}, {1'b0, 8'h00}, {1'b0, "z"}, {1'b1, 8'hFF},
      {1'b0, "0"}, {1'b0, CharPad}, {1'b0, "Z"}, {1'b1, "9"},
      {1'b1, "a"}, {1'b1, CharPad}
    };
    set_direction(DirDecode);
    foreach (seq[i]) send_item(seq[i][7:0], seq[i][8]);
    idle_input();
  endtask

  // Each direction must keep its partial string across a mode change.
  task automatic test_direction_switch();
    set_direction(DirEncode);
    send_item(8'hC3, 1'b0);
    idle_input();
    set_direction(DirDecode);
    send_item("Z", 1'b0);
    send_item("9", 1'b0);
    idle_input();
    set_direction(DirEncode);
    send_item(8'h3C, 1'b1);
    idle_input();
    set_direction(DirDecode);
    send_item("w", 1'b1);
    idle_input();
  endtask

  task automatic test_random_encode(input int n_items);
    set_direction(DirEncode);
    for (int sent = 0; sent < n_items; sent++) begin
      if (sent % 64 == 0) full_speed = ($urandom_range(0, 3) == 0);
      send_item(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
    end
    idle_input();
    full_speed = 1'b0;
  endtask

  // Strings of random length; a few end without a last marker and run into the next.
  task automatic test_random_decode(input int n_items);
    int          counted;
    int unsigned len;
    logic [7:0]  c;
    logic        l;
    counted = 0;
    set_direction(DirDecode);
    while (counted < n_items) begin
      full_speed = ($urandom_range(0, 4) == 0);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 10);
      for (int k = 0; k < len; k++) begin
        c = pick_char();
        l = (k == len - 1) && ($urandom_range(0, 9) != 0);
        if (item_matters(c, l)) counted++;
        send_item(c, l);
      end
    end
    idle_input();
    full_speed = 1'b0;
  endtask

  task automatic test_random_mixed(input int n_items);
    int          counted;
    int unsigned seg;
    logic        dir;
    logic [7:0]  c;
    logic        l;
    counted = 0;
    while (counted < n_items) begin
      dir = 1'($urandom_range(0, 1));
      set_direction(dir);
      seg = $urandom_range(1, 8);
      for (int k = 0; k < seg; k++) begin
        c = (dir == DirDecode) ? pick_char() : 8'($urandom_range(0, 255));
        l = ($urandom_range(0, 3) == 0);
        if (item_matters(c, l)) counted++;
        send_item(c, l);
      end
      idle_input();
    end
  endtask

  // Result side: a fresh stall length is drawn after every transfer.
  always @(posedge clk_i) begin : result_stall
    int unsigned hold_left;
    int unsigned draw;
    if (res_valid_o && !res_stall_i) begin
      draw = full_speed ? 0 : $urandom_range(0, 7);
      hold_left = draw;
      res_stall_i <= (draw != 0);
    end else if (hold_left != 0) begin
      res_stall_i <= (hold_left > 1);
      hold_left = hold_left - 1;
    end
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    b64s_res_t want;
    if (rst_ni && res_valid_o && !res_stall_i) begin
      n_results++;
      if (awaited_outputs.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual data %0h valid %b last %b",
                 $time, out_data_o, out_valid_o, out_last_o);
      end else begin
        want = awaited_outputs.pop_front();
        check_field("out_data", want.data, out_data_o);
        check_field("out_valid", want.valid, out_valid_o);
        check_field("out_last", want.last, out_last_o);
      end
    end
  end

  // Ends the run if no transfer of any kind happens for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (res_valid_o && !res_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_encode_groups();
    test_decode_cases();
    test_direction_switch();
    test_random_encode(400);
    test_random_decode(470);
    test_random_mixed(250);
    set_direction(DirEncode);
    while (awaited_outputs.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Run covered %0d bytes encoded, %0d characters decoded, %0d mode writes,",
             n_bytes_in, n_chars_in, n_cfg_writes);
    $display("and %0d results compared with %0d mismatches.", n_results, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
